### src/mrcc_pkg.sv
// Shared types and constants for the mixed-radix contingency counter.
// Used by mrcc_ctrl, mrcc_datapath and the top level; no dependencies.
`default_nettype none

package mrcc_pkg;

    // fixed field widths of the item formats
    localparam int NUM_PARENT_FIELDS = 6;
    localparam int VAL_W             = 4;   // child and parent value
    localparam int WEIGHT_W          = 12;
    localparam int NP_W              = 3;
    localparam int ARITY_W           = 5;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 12;
    localparam int RD_CFG_W          = 12;
    localparam int OUT_CNT_W         = 32;
    // j = sum of six 4x12 products fits in 19 bits; j*arity+k in 24 bits
    localparam int J_W               = 19;
    localparam int JK_W              = J_W + ARITY_W;
    localparam int PROD_W            = VAL_W + WEIGHT_W;

    // s_tdata layout, lowest bit first
    localparam int CHILD_LSB   = 0;
    localparam int PARENT_LSB  = 4;
    localparam int RD_CFG_LSB  = 28;
    localparam int RD_CHLD_LSB = 40;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 64;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_PARENTS = 3'd0,
        CFG_CHILD_ARITY = 3'd1,
        CFG_WEIGHT_0    = 3'd2,
        CFG_WEIGHT_1    = 3'd3,
        CFG_WEIGHT_2    = 3'd4,
        CFG_WEIGHT_3    = 3'd5,
        CFG_WEIGHT_4    = 3'd6,
        CFG_WEIGHT_5    = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_COUNT = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_INDEX,
        ST_ACCESS,
        ST_UPDATE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load;        // capture the accepted item
        logic mac_step;    // one multiply-accumulate of the parent index
        logic index;       // form j*arity+k and range flags
        logic read;        // issue table reads
        logic update;      // write back increment, capture counts
        logic clear_step;  // zero one entry of both tables
        logic res_zero;    // result is all zero
        logic res_oor;     // result is out of range
        logic out_load;    // move result into output register
    } dp_cmd_t;

    typedef struct packed {
        logic mac_done;
        logic addr_ok;
        logic clr_done;
    } dp_stat_t;

endpackage

`default_nettype wire

### src/mrcc_ctrl.sv
// Controller FSM of the contingency counter: sequences the index MAC, table
// access, clearing pass and output handshake. Depends on mrcc_pkg.
`default_nettype none

module mrcc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [1:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire mrcc_pkg::dp_stat_t stat_i,
    output mrcc_pkg::dp_cmd_t      cmd_o
);
    import mrcc_pkg::*;

    state_t state_reg, state_next;
    logic   clr_reply_reg, clr_reply_next;
    logic   m_tvalid_reg, m_tvalid_next;
    req_t   req_in;
    logic   out_free;

    assign req_in   = req_t'(s_tuser);
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;   // tables are zeroed after reset
            clr_reply_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reply_reg <= clr_reply_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (stat_i.clr_done) begin
                    state_next = clr_reply_reg ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (req_in)
                        REQ_CLEAR: state_next = ST_CLEAR;
                        REQ_COUNT: state_next = ST_MAC;
                        REQ_READ:  state_next = ST_INDEX;
                        default:   state_next = ST_RESP;
                    endcase
                end
            end
            ST_MAC: begin
                if (stat_i.mac_done) begin
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX:  state_next = ST_ACCESS;
            ST_ACCESS: state_next = stat_i.addr_ok ? ST_UPDATE : ST_RESP;
            ST_UPDATE: state_next = ST_RESP;
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd_o          = '0;
        s_tready       = 1'b0;
        clr_reply_next = clr_reply_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_CLEAR: begin
                cmd_o.clear_step = 1'b1;
                if (stat_i.clr_done) begin
                    cmd_o.res_zero = 1'b1;
                    clr_reply_next = 1'b0;
                end
            end
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd_o.load = s_tvalid;
                if (s_tvalid) begin
                    case (req_in)
                        REQ_CLEAR: clr_reply_next = 1'b1;
                        REQ_COUNT: cmd_o.res_zero = 1'b0;
                        REQ_READ:  cmd_o.res_zero = 1'b0;
                        default:   cmd_o.res_zero = 1'b1;
                    endcase
                end
            end
            ST_MAC:    cmd_o.mac_step = !stat_i.mac_done;
            ST_INDEX:  cmd_o.index = 1'b1;
            ST_ACCESS: begin
                cmd_o.read    = stat_i.addr_ok;
                cmd_o.res_oor = !stat_i.addr_ok;
            end
            ST_UPDATE: cmd_o.update = 1'b1;
            ST_RESP: begin
                if (out_free) begin
                    cmd_o.out_load = 1'b1;
                    m_tvalid_next  = 1'b1;
                end
            end
            default: cmd_o = '0;
        endcase
    end

endmodule

`default_nettype wire

### src/mrcc_datapath.sv
// Datapath of the contingency counter: config registers, shared index MAC,
// the two count memories with registered read, result and output registers.
// Depends on mrcc_pkg.
`default_nettype none

module mrcc_datapath #(
    parameter int TABLE_DEPTH = 4096,
    parameter int MAX_PARENTS = 6,
    parameter int MAX_ARITY   = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [mrcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mrcc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [1:0]                         s_tuser,
    input  wire logic [mrcc_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire mrcc_pkg::dp_cmd_t                  cmd_i,
    output mrcc_pkg::dp_stat_t                      stat_o,
    output logic [mrcc_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                    m_tuser
);
    import mrcc_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = COUNT_WIDTH;

    // configuration
    logic [NP_W-1:0]     num_parents_reg;
    logic [ARITY_W-1:0]  child_arity_reg;
    logic [WEIGHT_W-1:0] weight_reg [NUM_PARENT_FIELDS];

    // item registers
    req_t                req_reg;
    logic [VAL_W-1:0]    k_reg;
    logic [VAL_W-1:0]    pv_reg [NUM_PARENT_FIELDS];
    logic [J_W-1:0]      j_reg;
    logic [NP_W-1:0]     mac_cnt_reg;
    logic [JK_W-1:0]     jk_reg;
    logic                rng_ok_reg;
    logic [AW-1:0]       clr_ptr_reg;

    // tables
    logic [CW-1:0]       joint_mem  [TABLE_DEPTH];
    logic [CW-1:0]       parent_mem [TABLE_DEPTH];
    logic [CW-1:0]       joint_rd_reg, parent_rd_reg;

    // results
    logic [CW-1:0]       res_joint_reg, res_parent_reg;
    logic                res_oor_reg;
    logic [OUT_CNT_W-1:0] out_joint_reg, out_parent_reg;
    logic                out_oor_reg;

    logic [NP_W-1:0]     np_eff;
    logic [ARITY_W-1:0]  ar_eff;
    logic [PROD_W-1:0]   mac_prod;
    logic [JK_W-1:0]     jk_mul;
    logic                mem_we;
    logic [AW-1:0]       joint_wa, parent_wa;
    logic [CW-1:0]       joint_wd, parent_wd;
    logic [CW-1:0]       joint_inc, parent_inc;
    logic                is_count;

    assign np_eff = (int'(num_parents_reg) > MAX_PARENTS) ? NP_W'(MAX_PARENTS)
                                                           : num_parents_reg;
    assign ar_eff = (int'(child_arity_reg) > MAX_ARITY) ? ARITY_W'(MAX_ARITY)
                                                         : child_arity_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_parents_reg <= '0;
            child_arity_reg <= ARITY_W'(2);
            for (int i = 0; i < NUM_PARENT_FIELDS; i++) begin
                weight_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_NUM_PARENTS: num_parents_reg <= cfg_data[NP_W-1:0];
                CFG_CHILD_ARITY: child_arity_reg <= cfg_data[ARITY_W-1:0];
                CFG_WEIGHT_0:    weight_reg[0]   <= cfg_data;
                CFG_WEIGHT_1:    weight_reg[1]   <= cfg_data;
                CFG_WEIGHT_2:    weight_reg[2]   <= cfg_data;
                CFG_WEIGHT_3:    weight_reg[3]   <= cfg_data;
                CFG_WEIGHT_4:    weight_reg[4]   <= cfg_data;
                CFG_WEIGHT_5:    weight_reg[5]   <= cfg_data;
                default:         num_parents_reg <= num_parents_reg;
            endcase
        end
    end

    // one parent term per cycle
    assign mac_prod = PROD_W'(pv_reg[mac_cnt_reg]) * PROD_W'(weight_reg[mac_cnt_reg]);
    assign stat_o.mac_done = (mac_cnt_reg == np_eff);

    assign jk_mul = JK_W'(j_reg) * JK_W'(ar_eff);

    always_ff @(posedge aclk) begin
        if (cmd_i.load) begin
            req_reg     <= req_t'(s_tuser);
            mac_cnt_reg <= '0;
            for (int i = 0; i < NUM_PARENT_FIELDS; i++) begin
                pv_reg[i] <= s_tdata[PARENT_LSB + i*VAL_W +: VAL_W];
            end
            if (req_t'(s_tuser) == REQ_READ) begin
                k_reg <= s_tdata[RD_CHLD_LSB +: VAL_W];
                j_reg <= J_W'(s_tdata[RD_CFG_LSB +: RD_CFG_W]);
            end else begin
                k_reg <= s_tdata[CHILD_LSB +: VAL_W];
                j_reg <= '0;
            end
        end else if (cmd_i.mac_step) begin
            j_reg       <= j_reg + J_W'(mac_prod);
            mac_cnt_reg <= mac_cnt_reg + NP_W'(1);
        end
        if (cmd_i.index) begin
            jk_reg     <= jk_mul + JK_W'(k_reg);
            rng_ok_reg <= (ARITY_W'(k_reg) < ar_eff) && (j_reg < J_W'(TABLE_DEPTH));
        end
    end

    assign stat_o.addr_ok = rng_ok_reg && (jk_reg < JK_W'(TABLE_DEPTH));

    // clearing pass, one entry of each table per cycle
    assign stat_o.clr_done = (clr_ptr_reg == AW'(TABLE_DEPTH - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_ptr_reg <= '0;
        end else if (cmd_i.clear_step) begin
            clr_ptr_reg <= stat_o.clr_done ? '0 : clr_ptr_reg + AW'(1);
        end
    end

    assign is_count   = (req_reg == REQ_COUNT);
    assign joint_inc  = (joint_rd_reg == '1) ? joint_rd_reg : joint_rd_reg + CW'(1);
    assign parent_inc = (parent_rd_reg == '1) ? parent_rd_reg : parent_rd_reg + CW'(1);

    always_comb begin
        mem_we    = cmd_i.clear_step || (cmd_i.update && is_count);
        joint_wa  = jk_reg[AW-1:0];
        parent_wa = j_reg[AW-1:0];
        joint_wd  = joint_inc;
        parent_wd = parent_inc;
        if (cmd_i.clear_step) begin
            joint_wa  = clr_ptr_reg;
            parent_wa = clr_ptr_reg;
            joint_wd  = '0;
            parent_wd = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            joint_mem[joint_wa]   <= joint_wd;
            parent_mem[parent_wa] <= parent_wd;
        end
        if (cmd_i.read) begin
            joint_rd_reg  <= joint_mem[jk_reg[AW-1:0]];
            parent_rd_reg <= parent_mem[j_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.res_zero) begin
            res_joint_reg  <= '0;
            res_parent_reg <= '0;
            res_oor_reg    <= 1'b0;
        end else if (cmd_i.res_oor) begin
            res_joint_reg  <= '0;
            res_parent_reg <= '0;
            res_oor_reg    <= 1'b1;
        end else if (cmd_i.update) begin
            res_joint_reg  <= is_count ? joint_inc : joint_rd_reg;
            res_parent_reg <= is_count ? parent_inc : parent_rd_reg;
            res_oor_reg    <= 1'b0;
        end
        if (cmd_i.out_load) begin
            out_joint_reg  <= OUT_CNT_W'(res_joint_reg);
            out_parent_reg <= OUT_CNT_W'(res_parent_reg);
            out_oor_reg    <= res_oor_reg;
        end
    end

    assign m_tdata = {out_parent_reg, out_joint_reg};
    assign m_tuser = out_oor_reg;

    // a counted sample always leaves nonzero counts
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.update && is_count |=> res_joint_reg != '0 && res_parent_reg != '0)
        else $error("counted sample produced a zero count");

    // table reads only at addresses inside the tables
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.read |-> jk_reg < JK_W'(TABLE_DEPTH) && j_reg < J_W'(TABLE_DEPTH))
        else $error("table read outside depth");

    // clearing pass leaves the pointer at zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.clear_step && stat_o.clr_done |=> clr_ptr_reg == '0)
        else $error("clear pointer not back at zero");

endmodule

`default_nettype wire

### src/mixed_radix_contingency_counter.sv
// Top level of the mixed-radix contingency counter: ties controller and
// datapath to the stream and configuration ports. Depends on mrcc_pkg,
// mrcc_ctrl and mrcc_datapath.
//
//  channel | signals                            | carries
//  --------+------------------------------------+------------------------------
//  s_      | s_tvalid s_tready s_tdata s_tuser  | requests: clear, count, read
//  m_      | m_tvalid m_tready m_tdata m_tuser  | joint/parent counts, range flag
//  cfg_    | cfg_valid cfg_ready cfg_index/data | register writes, always ready
//
// Path from accept to m_tvalid: a count runs the shared MAC, one parent per cycle over
// num_parents (capped), then index multiply, registered read, write-back and response;
// a read starts at the index multiply, an unknown request goes straight to the response,
// a clear runs a clearing pass first; out of range skips write-back.
// s_tready rises with m_tvalid. After reset a clearing pass runs with s_tready low.
// A waiting result lets the next item in; only its last step stalls on m_tready.
`default_nettype none

module mixed_radix_contingency_counter #(
    parameter int TABLE_DEPTH = 4096,
    parameter int MAX_PARENTS = 6,
    parameter int MAX_ARITY   = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // child_value[3:0], parent_value_0..5[27:4], read_parent_config[39:28],
    // read_child_state[43:40], zero pad[47:44]
    input  wire logic [mrcc_pkg::S_TDATA_W-1:0]     s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]                         s_tuser,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // joint_count[31:0], parent_count[63:32]
    output logic [mrcc_pkg::M_TDATA_W-1:0]          m_tdata,
    // out_of_range[0]
    output logic                                    m_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [mrcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mrcc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mrcc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    mrcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat_i   (stat),
        .cmd_o    (cmd)
    );

    mrcc_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_PARENTS (MAX_PARENTS),
        .MAX_ARITY   (MAX_ARITY),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cmd_i     (cmd),
        .stat_o    (stat),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

### tb/tb_mixed_radix_contingency_counter.sv
// Self-checking testbench for mixed_radix_contingency_counter: directed and random
// requests with bursty input and a stalling output, checked by a scoreboard model.
// Depends on mrcc_pkg and the RTL of the block.
`timescale 1ns / 100ps
`default_nettype none

module tb_mixed_radix_contingency_counter;
    import mrcc_pkg::*;

    localparam int DEPTH        = 4096;
    localparam int PARENT_LIMIT = 6;
    localparam int ARITY_LIMIT  = 16;
    localparam int CNT_W        = 32;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 103;
    localparam int CLEAR_BUDGET = 20;

    typedef struct packed {
        logic [CNT_W-1:0] joint;
        logic [CNT_W-1:0] parent;
        logic             oor;
    } tally_t;

    typedef struct {
        int j;
        int k;
    } cfg_pair_t;

    // Keeps its own copy of both count tables and the configuration, and the
    // tallies still owed by the block in order.
    class contingency_ledger;
        logic [CNT_W-1:0]    joint_tab [DEPTH];
        logic [CNT_W-1:0]    parent_tab [DEPTH];
        logic [NP_W-1:0]     n_par;
        logic [ARITY_W-1:0]  arity;
        logic [WEIGHT_W-1:0] weight [NUM_PARENT_FIELDS];
        tally_t              expected_tallies [$];
        int                  mismatches;
        int                  checked;
        int                  oor_seen;

        function new();
            foreach (joint_tab[i]) begin
                joint_tab[i]  = '0;
                parent_tab[i] = '0;
            end
            n_par  = '0;
            arity  = ARITY_W'(2);
            foreach (weight[t]) weight[t] = '0;
            mismatches = 0;
            checked    = 0;
            oor_seen   = 0;
        endfunction

        function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_NUM_PARENTS: n_par = v[NP_W-1:0];
                CFG_CHILD_ARITY: arity = v[ARITY_W-1:0];
                default:         weight[idx - CFG_WEIGHT_0] = v[WEIGHT_W-1:0];
            endcase
        endfunction

        function bit find_slot(int j, int k, output int jk);
            int ar;
            ar = (int'(arity) > ARITY_LIMIT) ? ARITY_LIMIT : int'(arity);
            jk = 0;
            if (k >= ar || j >= DEPTH)
                return 1'b0;
            jk = j * ar + k;
            return jk < DEPTH;
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function void note_request(req_t req, logic [S_TDATA_W-1:0] d);
            tally_t t;
            int     j;
            int     k;
            int     jk;
            int     np;
            t = '0;
            case (req)
                REQ_CLEAR: begin
                    foreach (joint_tab[i]) begin
                        joint_tab[i]  = '0;
                        parent_tab[i] = '0;
                    end
                end
                REQ_COUNT: begin
                    np = (int'(n_par) > PARENT_LIMIT) ? PARENT_LIMIT : int'(n_par);
                    j  = 0;
                    for (int p = 0; p < np; p++)
                        j += int'(d[PARENT_LSB + VAL_W*p +: VAL_W]) * int'(weight[p]);
                    k = int'(d[CHILD_LSB +: VAL_W]);
                    if (find_slot(j, k, jk)) begin
                        joint_tab[jk] = bump(joint_tab[jk]);
                        parent_tab[j] = bump(parent_tab[j]);
                        t.joint  = joint_tab[jk];
                        t.parent = parent_tab[j];
                    end else begin
                        t.oor = 1'b1;
                    end
                end
                REQ_READ: begin
                    j = int'(d[RD_CFG_LSB +: RD_CFG_W]);
                    k = int'(d[RD_CHLD_LSB +: VAL_W]);
                    if (find_slot(j, k, jk)) begin
                        t.joint  = joint_tab[jk];
                        t.parent = parent_tab[j];
                    end else begin
                        t.oor = 1'b1;
                    end
                end
                default: ;  // unknown request leaves everything alone
            endcase
            expected_tallies.push_back(t);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] td, logic tu);
            tally_t want;
            if (expected_tallies.size() == 0) begin
                $error("result with no request outstanding: tdata %h tuser %b", td, tu);
                mismatches++;
                return;
            end
            want = expected_tallies.pop_front();
            checked++;
            if (tu)
                oor_seen++;
            if (td[31:0] !== want.joint) begin
                $error("joint_count: expected %0d, got %0d", want.joint, td[31:0]);
                mismatches++;
            end
            if (td[63:32] !== want.parent) begin
                $error("parent_count: expected %0d, got %0d", want.parent, td[63:32]);
                mismatches++;
            end
            if (tu !== want.oor) begin
                $error("out_of_range: expected %0d, got %0d", want.oor, tu);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_tallies.size();
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    contingency_ledger ledger = new();

    logic [CFG_DATA_W-1:0] cfg_plan [8];
    cfg_pair_t             recent_cfgs [$];
    int                    cycle_count  = 0;
    bit                    hold_request = 1'b0;
    int                    hold_left    = 0;
    int                    stall_mode   = 0;
    int                    mode_left    = 0;
    int                    burst_left   = 1;
    int                    n_sent [4];
    int                    n_settings   = 0;
    int                    clears_left  = CLEAR_BUDGET;

    mixed_radix_contingency_counter #(
        .TABLE_DEPTH (DEPTH),
        .MAX_PARENTS (PARENT_LIMIT),
        .MAX_ARITY   (ARITY_LIMIT),
        .COUNT_WIDTH (CNT_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results owed", cycle_count,
                     ledger.pending());
            $display("mixed_radix_contingency_counter verification failed");
            $finish;
        end
    end

    // Result side: check every transfer, stall in changing modes, and honor a
    // long hold-off when the stimulus asks for one.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            ledger.check_result(m_tdata, m_tuser);
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(8, 64);
            end
            mode_left--;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (cycle_count % 7 > 1);
            endcase
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_item(logic [3:0] child,
                                                       logic [23:0] parents,
                                                       logic [11:0] rd_cfg,
                                                       logic [3:0] rd_child);
        return {4'b0, rd_child, rd_cfg, parents, child};
    endfunction

    function automatic logic [S_TDATA_W-1:0] noise_word();
        return {4'b0, 12'($urandom), $urandom};
    endfunction

    // Holds tvalid high across back-to-back items; gaps come from the burst logic.
    task automatic offer(req_t req, logic [S_TDATA_W-1:0] d);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        ledger.note_request(req, d);
        n_sent[req]++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (ledger.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_registers();
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= cfg_plan[i];
            do @(posedge aclk); while (!cfg_ready);
            ledger.set_register(cfg_idx_t'(i), cfg_plan[i]);
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Mixed-radix weights for parents of equal cardinality; unused weights random, all when rand_weights.
    task automatic plan_setting(int np, int ar, int card, bit rand_weights);
        int w;
        int np_eff;
        np_eff = (np > PARENT_LIMIT) ? PARENT_LIMIT : np;
        w = 1;
        cfg_plan[CFG_NUM_PARENTS] = CFG_DATA_W'(np | ($urandom_range(0, 511) << NP_W));
        cfg_plan[CFG_CHILD_ARITY] = CFG_DATA_W'(ar | ($urandom_range(0, 127) << ARITY_W));
        for (int t = 0; t < NUM_PARENT_FIELDS; t++) begin
            if (t < np_eff && !rand_weights) begin
                cfg_plan[CFG_WEIGHT_0 + t] = CFG_DATA_W'(w);
                w = w * card;
            end else begin
                cfg_plan[CFG_WEIGHT_0 + t] = CFG_DATA_W'($urandom_range(0, 4095));
            end
        end
    endtask

    task automatic random_phase(int np, int ar, int card, int span, int phase);
        int          roll;
        int          np_eff;
        int          ar_eff;
        int          j;
        int          pick;
        logic [3:0]  child;
        logic [23:0] parents;
        cfg_pair_t   pr;
        np_eff = (np > PARENT_LIMIT) ? PARENT_LIMIT : np;
        ar_eff = (ar == 0) ? 1 : (ar > ARITY_LIMIT) ? ARITY_LIMIT : ar;
        recent_cfgs.delete();
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 3 && n == 40)
                hold_request = 1'b1;
            if (phase == 5 && n == 50)
                drain();
            roll = $urandom_range(0, 99);
            if (roll < 2 && clears_left > 0) begin
                clears_left--;
                offer(REQ_CLEAR, noise_word());
            end else if (roll < 5) begin
                offer(REQ_NONE, noise_word());
            end else if (roll < 12) begin
                offer($urandom_range(0, 99) < 50 ? REQ_COUNT : REQ_READ, noise_word());
            end else if (roll < 65) begin
                j = 0;
                parents = 24'($urandom);
                for (int t = 0; t < np_eff; t++) begin
                    parents[4*t +: 4] = 4'($urandom_range(0, card - 1));
                    j += int'(parents[4*t +: 4]) * int'(cfg_plan[CFG_WEIGHT_0 + t]);
                end
                child = 4'($urandom_range(0, ar_eff - 1));
                pr.j = j;
                pr.k = int'(child);
                recent_cfgs.push_back(pr);
                if (recent_cfgs.size() > 16)
                    void'(recent_cfgs.pop_front());
                offer(REQ_COUNT, pack_item(child, parents, 12'($urandom), 4'($urandom)));
            end else begin
                if (recent_cfgs.size() > 0 && $urandom_range(0, 99) < 60) begin
                    pick = $urandom_range(0, recent_cfgs.size() - 1);
                    pr   = recent_cfgs[pick];
                end else begin
                    pr.j = $urandom_range(0, span - 1);
                    pr.k = $urandom_range(0, ar_eff);
                end
                offer(REQ_READ, pack_item(4'($urandom), 24'($urandom), 12'(pr.j),
                                          4'(pr.k)));
            end
        end
    endtask

    initial begin
        int ph_np   [PHASES] = '{1, 2, 3, 6, 4, 0, 7, 5, 0};
        int ph_ar   [PHASES] = '{2, 4, 3, 2, 16, 16, 5, 7, 0};
        int ph_card [PHASES] = '{16, 8, 4, 3, 2, 2, 2, 3, 16};
        int span;
        foreach (n_sent[i]) n_sent[i] = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: two parents, four child states, unused weights at maximum
        cfg_plan[CFG_NUM_PARENTS] = CFG_DATA_W'(2);
        cfg_plan[CFG_CHILD_ARITY] = CFG_DATA_W'(4);
        cfg_plan[CFG_WEIGHT_0]    = CFG_DATA_W'(1);
        cfg_plan[CFG_WEIGHT_1]    = CFG_DATA_W'(3);
        for (int t = 2; t < NUM_PARENT_FIELDS; t++)
            cfg_plan[CFG_WEIGHT_0 + t] = '1;
        program_registers();
        offer(REQ_READ,  pack_item(4'd0, 24'h0, 12'd0, 4'd0));
        offer(REQ_COUNT, pack_item(4'd0, 24'h0, 12'd0, 4'd0));
        offer(REQ_COUNT, pack_item(4'd3, 24'hFFFF12, 12'd0, 4'd0));
        offer(REQ_COUNT, pack_item(4'd3, 24'hFFFF12, 12'hFFF, 4'hF));
        offer(REQ_READ,  pack_item(4'hF, 24'hFFFFFF, 12'd5, 4'd3));
        offer(REQ_READ,  pack_item(4'd0, 24'h0, 12'd5, 4'd4));      // child past arity
        offer(REQ_COUNT, pack_item(4'hF, 24'h0, 12'd0, 4'd0));      // child past arity
        offer(REQ_READ,  pack_item(4'd0, 24'h0, 12'hFFF, 4'd0));    // joint index off the end
        offer(REQ_READ,  pack_item(4'd0, 24'h0, 12'd1023, 4'd3));   // last table entry
        offer(REQ_NONE,  {4'b0, 44'hFFF_FFFF_FFFF});
        offer(REQ_COUNT, pack_item(4'd1, 24'hFFFFFF, 12'd0, 4'd0));
        offer(REQ_CLEAR, pack_item(4'd0, 24'h0, 12'd0, 4'd0));
        clears_left--;
        offer(REQ_READ,  pack_item(4'd0, 24'h0, 12'd5, 4'd3));
        drain();

        // parent count above the limit, arity above the limit, maximum weights
        cfg_plan[CFG_NUM_PARENTS] = '1;
        cfg_plan[CFG_CHILD_ARITY] = '1;
        for (int t = 0; t < NUM_PARENT_FIELDS; t++)
            cfg_plan[CFG_WEIGHT_0 + t] = '1;
        program_registers();
        offer(REQ_COUNT, pack_item(4'hF, 24'h0, 12'd0, 4'd0));
        offer(REQ_COUNT, pack_item(4'd0, 24'h000001, 12'd0, 4'd0));  // joint index too big
        offer(REQ_COUNT, pack_item(4'd0, 24'h000011, 12'd0, 4'd0));  // parent index too big
        offer(REQ_READ,  pack_item(4'd0, 24'h0, 12'd255, 4'hF));
        offer(REQ_READ,  pack_item(4'd0, 24'h0, 12'd256, 4'd0));
        offer(REQ_READ,  pack_item(4'd0, 24'h0, 12'd0, 4'hF));
        drain();

        // zero child states: everything lands out of range
        cfg_plan[CFG_NUM_PARENTS] = '0;
        cfg_plan[CFG_CHILD_ARITY] = CFG_DATA_W'(12'h020);
        program_registers();
        offer(REQ_COUNT, pack_item(4'd0, 24'h0, 12'd0, 4'd0));
        offer(REQ_READ,  pack_item(4'd0, 24'h0, 12'd0, 4'd0));

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            if (ph == PHASES - 1) begin
                ph_np[ph] = $urandom_range(0, 7);
                ph_ar[ph] = $urandom_range(17, 31);
            end
            plan_setting(ph_np[ph], ph_ar[ph], ph_card[ph], ph == PHASES - 1);
            program_registers();
            span = 1;
            for (int t = 0; t < ((ph_np[ph] > PARENT_LIMIT) ? PARENT_LIMIT : ph_np[ph]); t++)
                span = (span * ph_card[ph] > DEPTH) ? DEPTH : span * ph_card[ph];
            random_phase(ph_np[ph], ph_ar[ph], ph_card[ph], span, ph);
        end

        s_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent %0d counts, %0d reads, %0d clears, %0d unknown requests over %0d settings",
                 n_sent[REQ_COUNT], n_sent[REQ_READ], n_sent[REQ_CLEAR], n_sent[REQ_NONE],
                 n_settings);
        $display("checked %0d results (%0d out of range), %0d field mismatches",
                 ledger.checked, ledger.oor_seen, ledger.mismatches);
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("mixed_radix_contingency_counter verification clean");
        end else begin
            $display("mixed_radix_contingency_counter verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### mixed_radix_contingency_counter.f
src/mrcc_pkg.sv
src/mrcc_ctrl.sv
src/mrcc_datapath.sv
src/mixed_radix_contingency_counter.sv
tb/tb_mixed_radix_contingency_counter.sv
